// ===== hw/rtl/usb_device_tx_packetizer_top_macros.svh =====
// Assertion macros for the USB transmit packetizer checker.
`ifndef USB_DEVICE_TX_PACKETIZER_TOP_MACROS_SVH
`define USB_DEVICE_TX_PACKETIZER_TOP_MACROS_SVH

// Check a property outside reset.
`define USBTX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property that covers reset itself.
`define USBTX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/usbtx_pkg.sv =====
// Shared types, codes, constants and the CRC step of the USB transmit packetizer.
package usbtx_pkg;

  localparam int STORE_DEPTH_DEF   = 256;
  localparam int MAX_PACKET_DEF    = 8;
  localparam int NUM_ENDPOINTS_DEF = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int SIZE_W      = 7;   // packet size, up to 127 bytes
  localparam int OFFSET_W    = 9;   // transfer read offset
  localparam int LEN_W       = 18;  // signed remaining length and cap
  localparam int SUM_W       = 11;  // offset plus byte count

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_SETUP = 3'd2;
  localparam logic [2:0] OP_OUT   = 3'd3;
  localparam logic [2:0] OP_DATA0 = 3'd4;
  localparam logic [2:0] OP_DATA1 = 3'd5;
  localparam logic [2:0] OP_ACK   = 3'd6;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [7:0]  PID_DATA0 = 8'hC3;
  localparam logic [7:0]  PID_DATA1 = 8'h4B;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  // One job from the front to the back: a store write, or a run of results.
  typedef struct packed {
    logic                is_write;
    logic [7:0]          wr_index;
    logic [7:0]          wr_byte;
    logic                has_status;
    logic                status_busy;
    logic                has_packet;
    logic                pid_one;
    logic [3:0]          ep;
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] base;
    logic                has_finish;
    logic                finish_abort;
  } job_t;

  // Reflected CRC-16 over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  d;
    c = crc_in;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/usbtx_front.sv =====
// Front end: takes items, keeps transfer and toggle state, and classifies each item into a job.
module usbtx_front #(
  parameter int MAX_PACKET    = usbtx_pkg::MAX_PACKET_DEF,
  parameter int NUM_ENDPOINTS = usbtx_pkg::NUM_ENDPOINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        op,
  input  logic [7:0]        buffer_index,
  input  logic [7:0]        byte_value,
  input  logic [3:0]        endpoint,
  input  logic [7:0]        transfer_length,
  input  logic [15:0]       transfer_max,
  input  logic [15:0]       token_word,
  input  logic              cfg_write,
  input  logic [6:0]        cfg_data,
  output logic              job_push,
  output usbtx_pkg::job_t   job
);

  localparam logic signed [usbtx_pkg::LEN_W-1:0] MAX_S = usbtx_pkg::LEN_W'(MAX_PACKET);
  localparam logic [usbtx_pkg::OFFSET_W-1:0] STEP = usbtx_pkg::OFFSET_W'(MAX_PACKET);

  logic [6:0]                           dev_addr;
  logic [NUM_ENDPOINTS-1:0]             toggle, toggle_next;
  logic [3:0]                           token_ep, token_ep_next;
  logic [3:0]                           send_ep, send_ep_next;
  logic signed [usbtx_pkg::LEN_W-1:0]   left, left_next, cap, cap_next;
  logic [usbtx_pkg::OFFSET_W-1:0]       offset, offset_next;
  logic                                 active, active_next;

  logic [NUM_ENDPOINTS-1:0]             ep_mask, cand_tog;
  logic signed [usbtx_pkg::LEN_W-1:0]   cand_left, cand_cap, lim;
  logic [usbtx_pkg::OFFSET_W-1:0]       cand_base;
  logic [3:0]                           cand_ep;
  logic                                 job_valid;

  // Decode the token endpoint into a toggle mask; endpoints past the set read zero.
  always_comb begin
    for (int e = 0; e < NUM_ENDPOINTS; e++) ep_mask[e] = (token_ep == 4'(e));
  end

  // Pick the figures for the next packet: fresh transfer or advance after ACK.
  always_comb begin
    if (op == usbtx_pkg::OP_START) begin
      cand_left = usbtx_pkg::LEN_W'(transfer_length);
      cand_cap  = usbtx_pkg::LEN_W'(transfer_max);
      cand_base = '0;
      cand_ep   = endpoint;
      cand_tog  = toggle;
    end else begin
      cand_left = left - MAX_S;
      cand_cap  = cap - MAX_S;
      cand_base = offset + STEP;
      cand_ep   = send_ep;
      cand_tog  = toggle ^ ep_mask;
    end
    lim = (cand_left > MAX_S) ? MAX_S : cand_left;
    if (lim > cand_cap) lim = cand_cap;
  end

  // Classify the item and work out the next state.
  always_comb begin
    logic prep;
    prep          = 1'b0;
    toggle_next   = toggle;
    token_ep_next = token_ep;
    send_ep_next  = send_ep;
    left_next     = left;
    cap_next      = cap;
    offset_next   = offset;
    active_next   = active;
    job           = '0;
    job_valid     = 1'b0;
    case (op)
      usbtx_pkg::OP_WRITE: begin
        job.is_write = 1'b1;
        job.wr_index = buffer_index;
        job.wr_byte  = byte_value;
        job_valid    = 1'b1;
      end
      usbtx_pkg::OP_START: begin
        job_valid      = 1'b1;
        job.has_status = 1'b1;
        if (active || dev_addr == 7'd0) job.status_busy = 1'b1;
        else prep = 1'b1;
      end
      usbtx_pkg::OP_SETUP: begin
        token_ep_next = token_word[10:7];
        if (active) begin
          job_valid        = 1'b1;
          job.has_finish   = 1'b1;
          job.finish_abort = 1'b1;
        end
        active_next = 1'b0;
        left_next   = '0;
        cap_next    = '0;
        offset_next = '0;
      end
      usbtx_pkg::OP_OUT:   token_ep_next = token_word[10:7];
      usbtx_pkg::OP_DATA0: toggle_next = toggle | ep_mask;
      usbtx_pkg::OP_DATA1: toggle_next = toggle & ~ep_mask;
      usbtx_pkg::OP_ACK: begin
        toggle_next = toggle ^ ep_mask;
        prep        = active;
      end
      default: ;
    endcase

    // Prepare the next packet, or close the transfer.
    if (prep) begin
      job_valid = 1'b1;
      if (cand_left < 0 || cand_cap < 0 ||
          ((cand_left == 0 || cand_cap == 0) && cand_ep != 4'd0)) begin
        job.has_finish = 1'b1;
        active_next    = 1'b0;
        left_next      = '0;
        cap_next       = '0;
        offset_next    = '0;
      end else begin
        job.has_packet = 1'b1;
        job.pid_one    = |(cand_tog & ep_mask);
        job.ep         = cand_ep;
        job.base       = cand_base;
        job.size       = (cand_left == 0 || cand_cap == 0) ? '0 : usbtx_pkg::SIZE_W'(lim);
        active_next    = 1'b1;
        send_ep_next   = cand_ep;
        left_next      = cand_left;
        cap_next       = cand_cap;
        offset_next    = cand_base;
      end
    end
  end

  assign job_push = accept && job_valid;

  // Hold state; load the address on a config write, advance the rest only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= '0;
      toggle   <= '0;
      token_ep <= '0;
      send_ep  <= '0;
      left     <= '0;
      cap      <= '0;
      offset   <= '0;
      active   <= 1'b0;
    end else begin
      if (cfg_write) dev_addr <= cfg_data;
      if (accept) begin
        toggle   <= toggle_next;
        token_ep <= token_ep_next;
        send_ep  <= send_ep_next;
        left     <= left_next;
        cap      <= cap_next;
        offset   <= offset_next;
        active   <= active_next;
      end
    end
  end

endmodule

// ===== hw/rtl/usbtx_queue.sv =====
// Short job queue between the front and back ends.
module usbtx_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  usbtx_pkg::job_t   push_job,
  output logic              full,
  input  logic              pop,
  output logic              q_empty,
  output usbtx_pkg::job_t   head
);

  localparam int PTR_W = $clog2(usbtx_pkg::QUEUE_DEPTH);

  usbtx_pkg::job_t  slots [usbtx_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W + 1)'(usbtx_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign head    = slots[rd_ptr];

  // Store pushed jobs.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/usbtx_back.sv =====
// Back end: owns the payload store and plays jobs out as result words with CRC.
module usbtx_back #(
  parameter int STORE_DEPTH = usbtx_pkg::STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  usbtx_pkg::job_t   job,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        kind,
  output logic              status,
  output logic [7:0]        tx_byte,
  output logic [3:0]        tx_endpoint,
  output logic              last
);

  localparam int AW = $clog2(STORE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STAT = 3'd1;
  localparam logic [2:0] S_PID  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;
  localparam logic [2:0] S_CRCL = 3'd5;
  localparam logic [2:0] S_CRCH = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [7:0]                   mem [STORE_DEPTH];
  logic [7:0]                   rdata;
  logic [2:0]                   state, state_next;
  usbtx_pkg::job_t              cur;
  logic [usbtx_pkg::SIZE_W-1:0] cnt, cnt_next;
  logic [15:0]                  crc, crc_next;
  logic                         out_valid, emit_ok, emit, load, mem_we, rd_en;
  logic [1:0]                   e_kind;
  logic                         e_status, e_last;
  logic [7:0]                   e_byte;
  logic [usbtx_pkg::SUM_W-1:0]  rd_sum;
  logic [AW-1:0]                rd_addr, wr_addr;

  assign emit_ok = !out_valid || pop;
  assign empty   = !out_valid;
  assign rd_sum  = usbtx_pkg::SUM_W'(cur.base) + usbtx_pkg::SUM_W'(cnt);
  assign rd_addr = AW'(rd_sum);
  assign wr_addr = AW'(job.wr_index);

  // Sequence the words of one job.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    crc_next   = crc;
    job_pop    = 1'b0;
    load       = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    emit       = 1'b0;
    e_kind     = usbtx_pkg::KIND_BYTE;
    e_status   = 1'b0;
    e_byte     = '0;
    e_last     = 1'b0;
    case (state)
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.is_write) begin
            mem_we = 1'b1;
          end else begin
            load     = 1'b1;
            cnt_next = '0;
            crc_next = usbtx_pkg::CRC_INIT;
            if (job.has_status) state_next = S_STAT;
            else if (job.has_packet) state_next = S_PID;
            else state_next = S_FIN;
          end
        end
      end
      S_STAT: begin
        if (emit_ok) begin
          emit     = 1'b1;
          e_kind   = usbtx_pkg::KIND_STATUS;
          e_status = cur.status_busy;
          e_last   = !cur.has_packet && !cur.has_finish;
          if (cur.has_packet) state_next = S_PID;
          else if (cur.has_finish) state_next = S_FIN;
          else state_next = S_IDLE;
        end
      end
      S_PID: begin
        if (emit_ok) begin
          emit       = 1'b1;
          e_byte     = cur.pid_one ? usbtx_pkg::PID_DATA1 : usbtx_pkg::PID_DATA0;
          state_next = (cur.size == '0) ? S_CRCL : S_READ;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_DATA;
      end
      S_DATA: begin
        if (emit_ok) begin
          emit       = 1'b1;
          e_byte     = rdata;
          crc_next   = usbtx_pkg::crc_byte(crc, rdata);
          cnt_next   = cnt + 1'b1;
          state_next = (cnt_next == cur.size) ? S_CRCL : S_READ;
        end
      end
      S_CRCL: begin
        if (emit_ok) begin
          emit       = 1'b1;
          e_byte     = ~crc[7:0];
          state_next = S_CRCH;
        end
      end
      S_CRCH: begin
        if (emit_ok) begin
          emit       = 1'b1;
          e_byte     = ~crc[15:8];
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (emit_ok) begin
          emit       = 1'b1;
          e_kind     = usbtx_pkg::KIND_FINISH;
          e_status   = cur.finish_abort;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Write the store and register the read word.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= job.wr_byte;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Hold the current job and the running CRC.
  always_ff @(posedge clk) begin
    if (load) cur <= job;
    cnt <= cnt_next;
    crc <= crc_next;
  end

  // Advance the sequencer.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Output register: hold a word until popped.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= e_kind;
      status      <= e_status;
      tx_byte     <= e_byte;
      tx_endpoint <= (e_kind == usbtx_pkg::KIND_BYTE) ? cur.ep : 4'd0;
      last        <= e_last;
    end
  end

endmodule

// ===== hw/rtl/usb_device_tx_packetizer_top.sv =====
// Top level of the USB device transmit packetizer.
//
//   channel  | handshake             | words
//   ---------+-----------------------+---------------------------------------------
//   input    | push / full           | op, buffer_index, byte_value, endpoint, ...
//   result   | pop / empty           | kind, status, tx_byte, tx_endpoint, last
//   config   | cfg_valid / cfg_ready | device_address
//
// The front end takes one input word per cycle while the four-entry job queue has room.
// The back end fetches a job from the queue and emits its status, PID, data, CRC and notice
// words in order, each data byte after a registered store read, and fetches no new job until
// the current one is done. Store writes go through the same queue and keep their order.
// Reset is synchronous; the payload store is not cleared. A stalled result holds the
// back end, and the front end keeps taking words until the queue fills.
module usb_device_tx_packetizer_top #(
  parameter int STORE_DEPTH   = usbtx_pkg::STORE_DEPTH_DEF,
  parameter int MAX_PACKET    = usbtx_pkg::MAX_PACKET_DEF,
  parameter int NUM_ENDPOINTS = usbtx_pkg::NUM_ENDPOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [7:0]  buffer_index,
  input  logic [7:0]  byte_value,
  input  logic [3:0]  endpoint,
  input  logic [7:0]  transfer_length,
  input  logic [15:0] transfer_max,
  input  logic [15:0] token_word,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic        status,
  output logic [7:0]  tx_byte,
  output logic [3:0]  tx_endpoint,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  device_address
);

  usbtx_pkg::job_t push_job, head;
  logic            job_push, q_empty, job_pop;

  assign cfg_ready = 1'b1;

  usbtx_front #(
    .MAX_PACKET    (MAX_PACKET),
    .NUM_ENDPOINTS (NUM_ENDPOINTS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (push && !full),
    .op              (op),
    .buffer_index    (buffer_index),
    .byte_value      (byte_value),
    .endpoint        (endpoint),
    .transfer_length (transfer_length),
    .transfer_max    (transfer_max),
    .token_word      (token_word),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (device_address),
    .job_push        (job_push),
    .job             (push_job)
  );

  usbtx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (full),
    .pop      (job_pop),
    .q_empty  (q_empty),
    .head     (head)
  );

  usbtx_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (!q_empty),
    .job         (head),
    .job_pop     (job_pop),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .status      (status),
    .tx_byte     (tx_byte),
    .tx_endpoint (tx_endpoint),
    .last        (last)
  );

endmodule

// ===== hw/rtl/usbtx_checker.sv =====
// Port-level checker for the USB transmit packetizer, bound to the top level.
`include "usb_device_tx_packetizer_top_macros.svh"

module usbtx_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic        status,
  input logic [7:0]  tx_byte,
  input logic [3:0]  tx_endpoint,
  input logic        last
);

  `USBTX_ASSERT_RST(a_reset_empty, rst |=> empty, "result queue not empty after reset")
  `USBTX_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(kind) && $stable(tx_byte) && $stable(last)), "stalled result changed")
  `USBTX_ASSERT(a_kind_code, !empty |-> (kind == usbtx_pkg::KIND_STATUS || kind == usbtx_pkg::KIND_BYTE || kind == usbtx_pkg::KIND_FINISH), "bad result kind")
  `USBTX_ASSERT(a_byte_status, (!empty && kind == usbtx_pkg::KIND_BYTE) |-> !status, "status set on a byte")
  `USBTX_ASSERT(a_notice_clean, (!empty && kind != usbtx_pkg::KIND_BYTE) |-> (tx_byte == 8'd0 && tx_endpoint == 4'd0 && (kind == usbtx_pkg::KIND_STATUS || last)), "notice word malformed")

endmodule

bind usb_device_tx_packetizer_top usbtx_checker u_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the USB device transmit packetizer.
module testbench;
  import usbtx_pkg::*;

  localparam logic [2:0] OP_SPARE   = 3'd7;
  localparam int         WATCHDOG   = 5000;
  localparam int         SETTLE     = 60;
  localparam int         HOLD_LEN   = 300;
  localparam int         STORE_SIZE = 256;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [3:0]  ep;
    logic [7:0]  len;
    logic [15:0] maxv;
    logic [15:0] tok;
    bit          typed;     // expected words typed in below, not predicted
    int          n_typed;
    logic [1:0]  t_kind;
    logic        t_status;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       status;
    logic [7:0] b;
    logic [3:0] ep;
    logic       last;
  } word_t;

  logic        clk, rst;
  logic        push, full, empty, pop;
  logic [2:0]  op;
  logic [7:0]  buffer_index, byte_value, transfer_length, tx_byte;
  logic [3:0]  endpoint, tx_endpoint;
  logic [15:0] transfer_max, token_word;
  logic [1:0]  kind;
  logic        status, last;
  logic        cfg_valid, cfg_ready;
  logic [6:0]  device_address;

  usb_device_tx_packetizer_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .buffer_index(buffer_index), .byte_value(byte_value), .endpoint(endpoint),
    .transfer_length(transfer_length), .transfer_max(transfer_max),
    .token_word(token_word), .empty(empty), .pop(pop), .kind(kind),
    .status(status), .tx_byte(tx_byte), .tx_endpoint(tx_endpoint), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .device_address(device_address)
  );

  // Predictor state
  logic [7:0]  store_mem [STORE_SIZE];
  bit          store_written [STORE_SIZE];
  logic [15:0] toggles;
  logic [3:0]  tok_ep, snd_ep;
  int          left_bytes, cap_bytes;
  logic [8:0]  rd_offset;
  bit          xfer_active, pkt_queued, notice_due;
  logic [6:0]  bus_addr;

  word_t expected_words[$];
  int    errors;
  int    idle_pct, stall_pct;
  bit    hold_req;
  int    quiet_cycles;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic void emit_word(logic [1:0] k, logic s, logic [7:0] b, logic [3:0] e);
    word_t w;
    w = '{kind: k, status: s, b: b, ep: e, last: 1'b0};
    expected_words.push_back(w);
  endfunction

  function automatic void finish_xfer(logic aborted);
    if (notice_due) emit_word(KIND_FINISH, aborted, 8'd0, 4'd0);
    notice_due  = 0;
    left_bytes  = 0;
    cap_bytes   = 0;
    rd_offset   = '0;
    xfer_active = 0;
    pkt_queued  = 0;
  endfunction

  // Build the next packet: PID, data, inverted CRC low then high; or close the transfer.
  function automatic void build_packet();
    logic [7:0]  pid, d;
    logic [15:0] crc;
    int          size;
    if (pkt_queued) return;
    pkt_queued = 1;
    if (!xfer_active) begin
      pkt_queued = 0;
      return;
    end
    if (left_bytes < 0 || cap_bytes < 0) begin
      finish_xfer(1'b0);
      return;
    end
    pid = toggles[tok_ep] ? PID_DATA1 : PID_DATA0;
    if (left_bytes == 0 || cap_bytes == 0) begin
      if (snd_ep != 4'd0) begin
        finish_xfer(1'b0);
        return;
      end
      emit_word(KIND_BYTE, 1'b0, pid, snd_ep);
      emit_word(KIND_BYTE, 1'b0, 8'd0, snd_ep);
      emit_word(KIND_BYTE, 1'b0, 8'd0, snd_ep);
      return;
    end
    size = (left_bytes > MAX_PACKET_DEF) ? MAX_PACKET_DEF : left_bytes;
    if (size > cap_bytes) size = cap_bytes;
    emit_word(KIND_BYTE, 1'b0, pid, snd_ep);
    crc = 16'hFFFF;
    for (int i = 0; i < size; i++) begin
      d = store_mem[(rd_offset + i) % STORE_SIZE];
      emit_word(KIND_BYTE, 1'b0, d, snd_ep);
      for (int j = 0; j < 8; j++) begin
        if (crc[0] ^ d[j]) crc = (crc >> 1) ^ 16'hA001;
        else crc = crc >> 1;
      end
    end
    crc = ~crc;
    emit_word(KIND_BYTE, 1'b0, crc[7:0], snd_ep);
    emit_word(KIND_BYTE, 1'b0, crc[15:8], snd_ep);
  endfunction

  // Advance the packetizer by one accepted word and queue its results.
  function automatic void packetize(item_t it);
    int n0;
    n0 = expected_words.size();
    case (it.op)
      OP_WRITE: begin
        store_mem[it.idx]     = it.val;
        store_written[it.idx] = 1;
      end
      OP_START: begin
        if (xfer_active || pkt_queued || bus_addr == 7'd0) begin
          emit_word(KIND_STATUS, 1'b1, 8'd0, 4'd0);
        end else begin
          emit_word(KIND_STATUS, 1'b0, 8'd0, 4'd0);
          snd_ep      = it.ep;
          left_bytes  = it.len;
          cap_bytes   = it.maxv;
          rd_offset   = '0;
          xfer_active = 1;
          notice_due  = 1;
          build_packet();
        end
      end
      OP_SETUP: begin
        finish_xfer(1'b1);
        tok_ep = it.tok[10:7];
      end
      OP_OUT:   tok_ep = it.tok[10:7];
      OP_DATA0: toggles[tok_ep] = 1'b1;
      OP_DATA1: toggles[tok_ep] = 1'b0;
      OP_ACK: begin
        toggles[tok_ep] = ~toggles[tok_ep];
        left_bytes -= MAX_PACKET_DEF;
        cap_bytes  -= MAX_PACKET_DEF;
        rd_offset   = rd_offset + 9'(MAX_PACKET_DEF);
        if (left_bytes < 0 || cap_bytes < 0) finish_xfer(1'b0);
        pkt_queued = 0;
        if (xfer_active) build_packet();
        else finish_xfer(1'b0);
      end
      default: ;
    endcase
    if (expected_words.size() > n0) expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  // Offer one word until accepted, idling at random.
  task automatic offer(input item_t it);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(99) < idle_pct) begin
        push = 1'b0;
      end else begin
        push = 1'b1;
        op = it.op; buffer_index = it.idx; byte_value = it.val; endpoint = it.ep;
        transfer_length = it.len; transfer_max = it.maxv; token_word = it.tok;
      end
      @(posedge clk);
      if (push && !full) begin
        done = 1;
        if (it.typed) begin
          for (int i = 0; i < it.n_typed; i++)
            emit_word(it.t_kind, it.t_status, 8'd0, 4'd0);
          if (it.n_typed > 0) expected_words[expected_words.size() - 1].last = 1'b1;
        end else begin
          packetize(it);
        end
      end
    end
  endtask

  // Write every store entry a transfer of this length could read.
  task automatic fill_store(input int len);
    item_t w;
    for (int i = 0; i < len + MAX_PACKET_DEF && i < STORE_SIZE; i++) begin
      if (!store_written[i]) begin
        w = '{op: OP_WRITE, idx: 8'(i), val: 8'($urandom), ep: 4'($urandom),
              len: 8'($urandom), maxv: 16'($urandom), tok: 16'($urandom),
              typed: 0, n_typed: 0, t_kind: KIND_STATUS, t_status: 1'b0};
        offer(w);
      end
    end
  endtask

  task automatic send(input item_t it);
    if (it.op == OP_START && !xfer_active && !pkt_queued && bus_addr != 7'd0)
      fill_store(it.len);
    offer(it);
  endtask

  // Let every expected word drain, then give the back end time to go idle.
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_address(input logic [6:0] a);
    drain();
    @(negedge clk);
    cfg_valid      = 1'b1;
    device_address = a;
    do @(posedge clk); while (!cfg_ready);
    bus_addr = a;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic item_t random_item();
    item_t it;
    int p;
    it = '{op: OP_SPARE, idx: 8'($urandom), val: 8'($urandom), ep: 4'($urandom),
           len: 8'($urandom), maxv: 16'($urandom), tok: 16'($urandom),
           typed: 0, n_typed: 0, t_kind: KIND_STATUS, t_status: 1'b0};
    p = $urandom_range(99);
    if (xfer_active) begin
      if (p < 55)      it.op = OP_ACK;
      else if (p < 65) it.op = OP_OUT;
      else if (p < 72) it.op = ($urandom_range(1) != 0) ? OP_DATA0 : OP_DATA1;
      else if (p < 77) it.op = OP_SETUP;
      else if (p < 82) it.op = OP_START;
      else if (p < 94) it.op = OP_WRITE;
    end else begin
      if (p < 40)      it.op = OP_START;
      else if (p < 55) it.op = OP_WRITE;
      else if (p < 70) it.op = OP_OUT;
      else if (p < 80) it.op = ($urandom_range(1) != 0) ? OP_DATA0 : OP_DATA1;
      else if (p < 88) it.op = OP_ACK;
      else if (p < 94) it.op = OP_SETUP;
    end
    if (it.op == OP_START) begin
      if ($urandom_range(99) < 40) it.ep = 4'd0;
      p = $urandom_range(99);
      if (p < 70)      it.len = 8'($urandom_range(0, 24));
      else if (p < 90) it.len = 8'($urandom_range(0, 64));
      p = $urandom_range(99);
      if (p < 30)      it.maxv = 16'($urandom_range(0, 30));
      else if (p < 35) it.maxv = 16'd0;
      else if (p < 40) it.maxv = 16'hFFFF;
    end
    return it;
  endfunction

  task automatic run_phase(input logic [6:0] a, input int idle, input int stall,
                           input int count, input bit pressure);
    write_address(a);
    idle_pct  = idle;
    stall_pct = stall;
    if (pressure) hold_req = 1;
    for (int i = 0; i < count; i++) send(random_item());
  endtask

  // Directed rows; typed rows carry their expected words directly.
  item_t directed[$];

  function automatic item_t row(logic [2:0] o, logic [7:0] idx, logic [7:0] val,
                                logic [3:0] e, logic [7:0] len, logic [15:0] mx,
                                logic [15:0] tok);
    item_t it;
    it = '{op: o, idx: idx, val: val, ep: e, len: len, maxv: mx, tok: tok,
           typed: 0, n_typed: 0, t_kind: KIND_STATUS, t_status: 1'b0};
    return it;
  endfunction

  function automatic item_t typed_row(item_t it, int n, logic [1:0] k, logic s);
    it.typed    = 1;
    it.n_typed  = n;
    it.t_kind   = k;
    it.t_status = s;
    return it;
  endfunction

  // Check each word leaving the block against the oldest expectation.
  always @(posedge clk) begin
    word_t w;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d status=%0d byte=%h ep=%0d last=%0d",
                 $time, kind, status, tx_byte, tx_endpoint, last);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (kind !== w.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, w.kind, kind); errors++;
        end
        if (status !== w.status) begin
          $display("%0t: status expected %0d got %0d", $time, w.status, status); errors++;
        end
        if (tx_byte !== w.b) begin
          $display("%0t: tx_byte expected %h got %h", $time, w.b, tx_byte); errors++;
        end
        if (tx_endpoint !== w.ep) begin
          $display("%0t: tx_endpoint expected %0d got %0d", $time, w.ep, tx_endpoint);
          errors++;
        end
        if (last !== w.last) begin
          $display("%0t: last expected %0d got %0d", $time, w.last, last); errors++;
        end
      end
    end
  end

  // Drive pop; a hold request stops popping for a long counted stretch.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    errors = 0; quiet_cycles = 0; hold_req = 0;
    idle_pct = 0; stall_pct = 0;
    rst = 1'b1; push = 1'b0; cfg_valid = 1'b0; device_address = 7'd0;
    op = OP_WRITE; buffer_index = '0; byte_value = '0; endpoint = '0;
    transfer_length = '0; transfer_max = '0; token_word = '0;
    toggles = '0; tok_ep = '0; snd_ep = '0; left_bytes = 0; cap_bytes = 0;
    rd_offset = '0; xfer_active = 0; pkt_queued = 0; notice_due = 0; bus_addr = '0;
    foreach (store_written[i]) store_written[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Address zero refuses every start.
    write_address(7'd0);
    send(typed_row(row(OP_START, 0, 0, 4'd3, 8'd5, 16'd100, 0), 1, KIND_STATUS, 1'b1));
    send(typed_row(row(OP_START, 0, 0, 4'd0, 8'd0, 16'd0, 0), 1, KIND_STATUS, 1'b1));

    // Directed walk at the top address.
    directed.push_back(row(OP_OUT,   0, 0, 0, 0, 0, 16'(2 << 7)));
    directed.push_back(row(OP_DATA1, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_START, 0, 0, 4'd2, 8'd10, 16'hFFFF, 0));
    directed.push_back(typed_row(row(OP_START, 0, 0, 4'd1, 8'd3, 16'd3, 0),
                                 1, KIND_STATUS, 1'b1));
    directed.push_back(row(OP_ACK,   0, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_ACK,   0, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_START, 0, 0, 4'd0, 8'd0, 16'd50, 0));
    directed.push_back(row(OP_ACK,   0, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_START, 0, 0, 4'd5, 8'd0, 16'd100, 0));
    directed.push_back(row(OP_START, 0, 0, 4'd1, 8'd255, 16'd3, 0));
    directed.push_back(row(OP_SETUP, 0, 0, 0, 0, 0, 16'hFFFF));
    directed.push_back(row(OP_DATA0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_ACK,   0, 0, 0, 0, 0, 0));
    directed.push_back(typed_row(row(OP_SPARE, 8'hFF, 8'hFF, 4'hF, 8'hFF, 16'hFFFF,
                                     16'hFFFF), 0, KIND_STATUS, 1'b0));
    directed.push_back(row(OP_WRITE, 8'hFF, 8'hFF, 0, 0, 0, 0));
    directed.push_back(row(OP_WRITE, 8'h00, 8'h00, 0, 0, 0, 0));
    directed.push_back(row(OP_START, 0, 0, 4'hF, 8'd8, 16'd8, 0));
    directed.push_back(row(OP_ACK,   0, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_START, 0, 0, 4'd0, 8'd255, 16'd0, 0));
    directed.push_back(row(OP_SETUP, 0, 0, 0, 0, 0, 16'd0));
    write_address(7'd127);
    foreach (directed[i]) send(directed[i]);

    // Random phases across addresses and idle patterns; the store fill above
    // already writes every entry of the store.
    run_phase(7'($urandom_range(1, 126)), 0, 0, 45, 0);
    run_phase(7'd1, 52, 0, 30, 1);
    run_phase(7'($urandom_range(1, 126)), 0, 52, 30, 0);
    run_phase(7'd127, 16, 16, 30, 0);
    run_phase(7'd0, 16, 16, 10, 0);

    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
